[hw/rtl/tdc_histogram_quantile_assert.svh]
// assertion macros shared by the rtl of the tdc histogram block
// no dependencies; taken in by `include where checks are written
`ifndef TDC_HISTOGRAM_QUANTILE_ASSERT_SVH
`define TDC_HISTOGRAM_QUANTILE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define THQ_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error("tdc_histogram_quantile: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define THQ_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error("tdc_histogram_quantile: next-cycle check failed");

`endif

[hw/rtl/thq_pkg.sv]
// shared types and fixed constants of the tdc histogram quantile block
// no dependencies; used by the front, back and top rtl files and bench
package thq_pkg;

	localparam int COUNT_W        = 32;
	localparam int BIN_OUT_W      = 6;
	localparam int TDC_W          = 6;
	localparam int ADC_W          = 8;
	localparam int ETA_W          = 6;
	localparam int DEPTH_W        = 3;
	localparam int PERMILLE_W     = 10;
	localparam int PERMILLE_SCALE = 1000;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 10;

	localparam logic [ADC_W-1:0]      ADC_THRESHOLD_RST = 8'd33;
	localparam logic [PERMILLE_W-1:0] PERMILLE_RST      = 10'd900;

	// queue depths between the parts of the block
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	typedef enum logic {
		OP_HIT   = 1'b0,
		OP_QUERY = 1'b1
	} thq_op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ADC_THRESHOLD = 1'b0,
		REG_QUANTILE      = 1'b1
	} thq_reg_e;

	// classification of one request, produced by the front part
	typedef struct packed {
		thq_op_e op;
		logic    cell_ok;
		logic    counted;
		logic    dropped;
	} thq_ctrl_t;

	typedef struct packed {
		thq_op_e                kind;
		logic                   hit_counted;
		logic                   hit_dropped_code;
		logic [BIN_OUT_W-1:0]   quantile_bin;
		logic [COUNT_W-1:0]     cell_total;
	} thq_result_t;

endpackage

[hw/rtl/thq_fifo.sv]
// small first-in first-out queue of register storage
// depends on nothing; used for the request queue and the result buffer
module thq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       full,
	output logic                       empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign count    = count_q;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/thq_front.sv]
// front part: decodes a request into cell validity, hit flags and a store address
// depends on thq_pkg
module thq_front #(
	parameter int ETA_ROWS   = 30,
	parameter int DEPTH_ROWS = 8,
	parameter int TDC_BINS   = 51,
	parameter int ADDR_W     = 14
) (
	input  logic                                 operation,
	input  logic signed [thq_pkg::ETA_W-1:0]     eta_index,
	input  logic        [thq_pkg::DEPTH_W-1:0]   depth_index,
	input  logic        [thq_pkg::TDC_W-1:0]     tdc_code,
	input  logic        [thq_pkg::ADC_W-1:0]     adc_code,
	input  logic        [thq_pkg::ADC_W-1:0]     adc_threshold,
	output thq_pkg::thq_ctrl_t                   ctrl,
	output logic        [ADDR_W-1:0]             addr
);

	logic [thq_pkg::ETA_W-1:0] eta_bits;
	logic [thq_pkg::ETA_W-1:0] mag;
	logic                      row_ok;
	logic                      depth_ok;
	logic                      cell_ok;
	logic                      bin_ok;
	logic                      pass;
	logic                      is_hit;
	logic [ADDR_W-1:0]         base;

	assign eta_bits = eta_index;
	// magnitude of the two's complement eta, -32 gives 32
	assign mag      = eta_bits[thq_pkg::ETA_W-1] ? (~eta_bits + 1'b1) : eta_bits;
	assign row_ok   = {1'b0, mag} < (thq_pkg::ETA_W + 1)'(ETA_ROWS);
	assign depth_ok = {2'b00, depth_index} < (thq_pkg::DEPTH_W + 2)'(DEPTH_ROWS);
	assign cell_ok  = row_ok && depth_ok;
	assign bin_ok   = {1'b0, tdc_code} < (thq_pkg::TDC_W + 1)'(TDC_BINS);
	assign is_hit   = (thq_pkg::thq_op_e'(operation) == thq_pkg::OP_HIT);
	assign pass     = is_hit && cell_ok && (adc_code > adc_threshold);

	assign base = (ADDR_W'(mag) * ADDR_W'(DEPTH_ROWS) + ADDR_W'(depth_index))
		* ADDR_W'(TDC_BINS);

	always_comb begin
		ctrl.op      = thq_pkg::thq_op_e'(operation);
		ctrl.cell_ok = cell_ok;
		ctrl.counted = pass && bin_ok;
		ctrl.dropped = pass && !bin_ok;
		addr         = is_hit ? (base + ADDR_W'(tdc_code)) : base;
	end

endmodule

[hw/rtl/thq_back.sv]
// back part: bin store with clearing pass, hit read-modify-write and quantile scan
// depends on thq_pkg; fed by the request queue, feeds the result buffer
module thq_back #(
	parameter int ETA_ROWS   = 30,
	parameter int DEPTH_ROWS = 8,
	parameter int TDC_BINS   = 51,
	parameter int ADDR_W     = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	input  thq_pkg::thq_ctrl_t                 cmd_ctrl,
	input  logic [ADDR_W-1:0]                  cmd_addr,
	output logic                               cmd_pop,
	input  logic [thq_pkg::PERMILLE_W-1:0]     quantile_permille,
	input  logic [thq_pkg::RES_CNT_W-1:0]      res_count,
	input  logic                               res_full,
	output logic                               res_push,
	output thq_pkg::thq_result_t               res_data,
	output logic                               clearing
);

	localparam int STORE  = ETA_ROWS * DEPTH_ROWS * TDC_BINS;
	localparam int CW     = thq_pkg::COUNT_W;
	localparam int CNT_W  = $clog2(TDC_BINS + 1);
	localparam int BIN_W  = $clog2(TDC_BINS);
	localparam int TOT_W  = CW + $clog2(TDC_BINS);
	localparam int LIM_W  = TOT_W + thq_pkg::PERMILLE_W;
	localparam int PROD_W = CW + thq_pkg::PERMILLE_W;
	localparam int CRD_W  = thq_pkg::RES_CNT_W + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RUN,
		ST_SUM,
		ST_LIMIT,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [CW-1:0]     mem [STORE];
	logic [CW-1:0]     rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CW-1:0]     mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	logic [ADDR_W-1:0] clr_addr_q;

	logic               hit_v_s1;
	thq_pkg::thq_ctrl_t hit_ctrl_s1;
	logic [ADDR_W-1:0]  hit_addr_s1;
	logic               fwd_v_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	logic [CW-1:0]      fwd_data_q;

	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              scan_v_s1;
	logic              scan_v_s2;
	logic [BIN_W-1:0]  bidx_s1;
	logic [BIN_W-1:0]  bidx_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [TOT_W-1:0]  total_q;
	logic [LIM_W-1:0]  limit_q;
	logic [LIM_W-1:0]  run_q;
	logic              found_q;
	logic [BIN_W-1:0]  qbin_q;

	logic              head_hit;
	logic              head_query;
	logic [CRD_W-1:0]  credit_used;
	logic              hit_go;
	logic              qry_go;
	logic              scan_issue;
	logic [CW-1:0]     cur_val;
	logic [CW-1:0]     inc_val;
	logic [LIM_W-1:0]  run_next;
	logic              scan_hit;

	assign clearing = (state_q == ST_CLEAR);

	assign head_hit    = cmd_valid && (cmd_ctrl.op == thq_pkg::OP_HIT);
	assign head_query  = cmd_valid && (cmd_ctrl.op == thq_pkg::OP_QUERY);
	// every hit in flight already holds a place in the result buffer
	assign credit_used = CRD_W'(res_count) + CRD_W'(hit_v_s1);
	assign hit_go      = (state_q == ST_RUN) && head_hit
		&& (credit_used < CRD_W'(thq_pkg::RES_DEPTH));
	// a query waits for hits ahead of it to finish their write
	assign qry_go      = (state_q == ST_RUN) && head_query && !hit_v_s1 && !res_full;
	assign cmd_pop     = hit_go || qry_go;

	assign scan_issue = ((state_q == ST_SUM) || (state_q == ST_SCAN))
		&& (scan_cnt_q < CNT_W'(TDC_BINS));

	// read issued in the cycle before may miss the write of that same cycle
	assign cur_val  = (fwd_v_q && (fwd_addr_q == hit_addr_s1)) ? fwd_data_q : rdata_q;
	assign inc_val  = (&cur_val) ? cur_val : cur_val + 1'b1;
	assign run_next = run_q + LIM_W'(prod_s2);
	assign scan_hit = scan_v_s2 && !found_q && (bidx_s2 != '0) && (run_next > limit_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_addr_s1;
		mem_wdata = inc_val;
		if (clearing) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (hit_v_s1 && hit_ctrl_s1.counted) begin
			mem_we = 1'b1;
		end
		mem_re    = hit_go || scan_issue;
		mem_raddr = hit_go ? cmd_addr : (base_q + ADDR_W'(scan_cnt_q));
	end

	always_comb begin
		res_push = 1'b0;
		res_data = '0;
		if (hit_v_s1) begin
			res_push                  = 1'b1;
			res_data.kind             = thq_pkg::OP_HIT;
			res_data.hit_counted      = hit_ctrl_s1.counted;
			res_data.hit_dropped_code = hit_ctrl_s1.dropped;
		end else if (qry_go && !cmd_ctrl.cell_ok) begin
			res_push      = 1'b1;
			res_data.kind = thq_pkg::OP_QUERY;
		end else if ((state_q == ST_DONE) && !res_full) begin
			res_push              = 1'b1;
			res_data.kind         = thq_pkg::OP_QUERY;
			res_data.quantile_bin = thq_pkg::BIN_OUT_W'(qbin_q);
			res_data.cell_total   = (|total_q[TOT_W-1:CW]) ? '1 : total_q[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			hit_v_s1   <= 1'b0;
			fwd_v_q    <= 1'b0;
			scan_cnt_q <= '0;
			scan_v_s1  <= 1'b0;
			scan_v_s2  <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			hit_v_s1  <= hit_go;
			fwd_v_q   <= mem_we && !clearing;
			scan_v_s1 <= scan_issue;
			scan_v_s2 <= scan_v_s1 && (state_q == ST_SCAN);
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (scan_hit) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(STORE - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (qry_go && cmd_ctrl.cell_ok) begin
						state_q    <= ST_SUM;
						scan_cnt_q <= '0;
					end
				end
				ST_SUM: begin
					if (!scan_issue && !scan_v_s1) begin
						state_q    <= ST_LIMIT;
						scan_cnt_q <= '0;
					end
				end
				ST_LIMIT: begin
					state_q <= ST_SCAN;
					found_q <= 1'b0;
				end
				ST_SCAN: begin
					if (!scan_issue && !scan_v_s1 && !scan_v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hit_go) begin
			hit_ctrl_s1 <= cmd_ctrl;
			hit_addr_s1 <= cmd_addr;
		end
		if (mem_we) begin
			fwd_addr_q <= mem_waddr;
			fwd_data_q <= mem_wdata;
		end
		if (qry_go) begin
			base_q  <= cmd_addr;
			total_q <= '0;
		end else if ((state_q == ST_SUM) && scan_v_s1) begin
			total_q <= total_q + TOT_W'(rdata_q);
		end
		if (state_q == ST_LIMIT) begin
			limit_q <= LIM_W'(quantile_permille) * LIM_W'(total_q);
			run_q   <= '0;
			qbin_q  <= '0;
		end else if (scan_v_s2) begin
			run_q <= run_next;
			if (scan_hit) begin
				qbin_q <= bidx_s2;
			end
		end
		bidx_s1 <= scan_cnt_q[BIN_W-1:0];
		bidx_s2 <= bidx_s1;
		prod_s2 <= PROD_W'(rdata_q) * PROD_W'(thq_pkg::PERMILLE_SCALE);
	end

endmodule

[hw/rtl/tdc_histogram_quantile.sv]
// tdc_histogram_quantile: per-cell histograms of tdc codes with a quantile query.
// Request channel (item_valid/item_stall): operation 0 records a hit, 1 queries the
// cell given by |eta_index| and depth_index. Result channel (result_valid/
// result_stall) returns one result per request, in request order.
// Registers are written on cfg_valid; the user must write them only while the block is
// idle (not enforced by the block); cfg_ready is always high. After reset the bin
// memory is swept to zero, one bin a cycle, over all ETA_ROWS*DEPTH_ROWS*TDC_BINS bins
// (12240 by default); item_stall is high meanwhile. A hit is one read-modify-write of
// the bin memory in the back part, which has a read and a write port, so hits run at
// one per cycle while the result buffer has room. A query to a cell in the table
// makes two passes over the cell's bins through the same read port, a sum pass and a
// cumulative pass, holding the back part until its result is pushed. A four-entry
// request queue separates the decoder from the memory side, and a four-entry result
// buffer lets requests keep flowing while result_stall is high; item_stall rises once
// the request queue is full. Results hold steady while stalled.
// Depends on thq_pkg, thq_front, thq_fifo and thq_back.
`include "tdc_histogram_quantile_assert.svh"

module tdc_histogram_quantile #(
	parameter int ETA_ROWS   = 30,
	parameter int DEPTH_ROWS = 8,
	parameter int TDC_BINS   = 51
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  operation,
	input  logic signed [thq_pkg::ETA_W-1:0]      eta_index,
	input  logic        [thq_pkg::DEPTH_W-1:0]    depth_index,
	input  logic        [thq_pkg::TDC_W-1:0]      tdc_code,
	input  logic        [thq_pkg::ADC_W-1:0]      adc_code,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic                                  result_kind,
	output logic                                  hit_counted,
	output logic                                  hit_dropped_code,
	output logic        [thq_pkg::BIN_OUT_W-1:0]  quantile_bin,
	output logic        [thq_pkg::COUNT_W-1:0]    cell_total,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [thq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [thq_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(ETA_ROWS * DEPTH_ROWS * TDC_BINS);
	localparam int CTRL_W = $bits(thq_pkg::thq_ctrl_t);
	localparam int CMD_W  = CTRL_W + ADDR_W;
	localparam int RES_W  = $bits(thq_pkg::thq_result_t);

	logic [thq_pkg::ADC_W-1:0]      adc_threshold_q;
	logic [thq_pkg::PERMILLE_W-1:0] quantile_permille_q;

	thq_pkg::thq_ctrl_t  front_ctrl;
	logic [ADDR_W-1:0]   front_addr;
	logic                cmd_push;
	logic [CMD_W-1:0]    cmd_head;
	logic                cmd_pop;
	logic [$clog2(thq_pkg::CMD_DEPTH+1)-1:0] cmd_count;
	logic                cmd_full;
	logic                cmd_empty;
	thq_pkg::thq_ctrl_t  cmd_ctrl;
	logic [ADDR_W-1:0]   cmd_addr;

	logic                          res_push;
	thq_pkg::thq_result_t          res_data;
	logic                          res_pop;
	logic [RES_W-1:0]              res_head;
	thq_pkg::thq_result_t          res_out;
	logic [thq_pkg::RES_CNT_W-1:0] res_count;
	logic                          res_full;
	logic                          res_empty;
	logic                          clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_threshold_q     <= thq_pkg::ADC_THRESHOLD_RST;
			quantile_permille_q <= thq_pkg::PERMILLE_RST;
		end else if (cfg_valid) begin
			unique case (thq_pkg::thq_reg_e'(cfg_index))
				thq_pkg::REG_ADC_THRESHOLD: adc_threshold_q <= cfg_data[thq_pkg::ADC_W-1:0];
				thq_pkg::REG_QUANTILE:      quantile_permille_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	thq_front #(
		.ETA_ROWS   (ETA_ROWS),
		.DEPTH_ROWS (DEPTH_ROWS),
		.TDC_BINS   (TDC_BINS),
		.ADDR_W     (ADDR_W)
	) u_front (
		.operation     (operation),
		.eta_index     (eta_index),
		.depth_index   (depth_index),
		.tdc_code      (tdc_code),
		.adc_code      (adc_code),
		.adc_threshold (adc_threshold_q),
		.ctrl          (front_ctrl),
		.addr          (front_addr)
	);

	// nothing enters until the bin memory sweep has finished
	assign item_stall = cmd_full || clearing;
	assign cmd_push   = item_valid && !item_stall;

	thq_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (thq_pkg::CMD_DEPTH)
	) u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data ({front_ctrl, front_addr}),
		.pop       (cmd_pop),
		.pop_data  (cmd_head),
		.count     (cmd_count),
		.full      (cmd_full),
		.empty     (cmd_empty)
	);

	assign cmd_ctrl = thq_pkg::thq_ctrl_t'(cmd_head[CMD_W-1 -: CTRL_W]);
	assign cmd_addr = cmd_head[ADDR_W-1:0];

	thq_back #(
		.ETA_ROWS   (ETA_ROWS),
		.DEPTH_ROWS (DEPTH_ROWS),
		.TDC_BINS   (TDC_BINS),
		.ADDR_W     (ADDR_W)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (!cmd_empty),
		.cmd_ctrl          (cmd_ctrl),
		.cmd_addr          (cmd_addr),
		.cmd_pop           (cmd_pop),
		.quantile_permille (quantile_permille_q),
		.res_count         (res_count),
		.res_full          (res_full),
		.res_push          (res_push),
		.res_data          (res_data),
		.clearing          (clearing)
	);

	thq_fifo #(
		.WIDTH (RES_W),
		.DEPTH (thq_pkg::RES_DEPTH)
	) u_res_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.pop       (res_pop),
		.pop_data  (res_head),
		.count     (res_count),
		.full      (res_full),
		.empty     (res_empty)
	);

	assign res_out          = thq_pkg::thq_result_t'(res_head);
	assign result_valid     = !res_empty;
	assign res_pop          = result_valid && !result_stall;
	assign result_kind      = res_out.kind;
	assign hit_counted      = res_out.hit_counted;
	assign hit_dropped_code = res_out.hit_dropped_code;
	assign quantile_bin     = res_out.quantile_bin;
	assign cell_total       = res_out.cell_total;

	// no request may be waiting or answered before the memory sweep ends
	`THQ_ASSERT_NOW(a_idle_while_clearing, clk, arst_n, clearing, (cmd_count == '0) && res_empty)
	// the back part only takes a request that is there
	`THQ_ASSERT_NOW(a_pop_needs_request, clk, arst_n, cmd_pop, !cmd_empty)
	// credit on the result buffer must keep every result from overflowing it
	`THQ_ASSERT_NOW(a_result_fits, clk, arst_n, res_push, !res_full)

endmodule

[bench/tdc_histogram_quantile_tb.sv]
// self-checking bench for tdc_histogram_quantile: per-cell tdc histograms and quantile queries
// depends on thq_pkg and the tdc_histogram_quantile rtl; reads no files
`timescale 1ns / 1ps

module tdc_histogram_quantile_tb;
	import thq_pkg::*;

	localparam int ETA_ROWS    = 30;
	localparam int DEPTH_ROWS  = 8;
	localparam int TDC_BINS    = 51;
	localparam int STORE_SIZE  = ETA_ROWS * DEPTH_ROWS * TDC_BINS;
	localparam int HOT_CELLS   = 3;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 175;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		thq_op_e                   op;
		logic signed [ETA_W-1:0]   eta;
		logic        [DEPTH_W-1:0] depth;
		logic        [TDC_W-1:0]   tdc;
		logic        [ADC_W-1:0]   adc;
	} hist_req_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic                   operation = 1'b0;
	logic signed [ETA_W-1:0]   eta_index = '0;
	logic        [DEPTH_W-1:0] depth_index = '0;
	logic        [TDC_W-1:0]   tdc_code = '0;
	logic        [ADC_W-1:0]   adc_code = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic                   result_kind;
	logic                   hit_counted;
	logic                   hit_dropped_code;
	logic [BIN_OUT_W-1:0]   quantile_bin;
	logic [COUNT_W-1:0]     cell_total;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// shadow of the block: bin store and registers
	bit [COUNT_W-1:0]    bin_tally [0:STORE_SIZE-1];
	bit [ADC_W-1:0]      thr_shadow = ADC_THRESHOLD_RST;
	bit [PERMILLE_W-1:0] permille_shadow = PERMILLE_RST;

	hist_req_t   pending_reqs [$];
	hist_req_t   next_req;
	thq_result_t expected_results [$];

	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hot_mag [HOT_CELLS];
	int unsigned hot_depth [HOT_CELLS];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned hits_seen = 0, queries_seen = 0, hits_counted = 0, hits_dropped = 0;
	int unsigned nonzero_answers = 0, settings_used = 0;

	int unsigned phase_thr  [0:PHASES-1] = '{33, 0, 255, 128, 10, 200, 50, 90};
	int unsigned phase_perm [0:PHASES-1] = '{900, 0, 1000, 500, 1023, 1, 999, 750};
	int unsigned phase_send [0:PHASES-1] = '{0, 63, 0, 24, 0, 63, 0, 24};
	int unsigned phase_recv [0:PHASES-1] = '{0, 0, 63, 24, 0, 0, 63, 24};

	tdc_histogram_quantile #(
		.ETA_ROWS  (ETA_ROWS),
		.DEPTH_ROWS(DEPTH_ROWS),
		.TDC_BINS  (TDC_BINS)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.operation       (operation),
		.eta_index       (eta_index),
		.depth_index     (depth_index),
		.tdc_code        (tdc_code),
		.adc_code        (adc_code),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_kind     (result_kind),
		.hit_counted     (hit_counted),
		.hit_dropped_code(hit_dropped_code),
		.quantile_bin    (quantile_bin),
		.cell_total      (cell_total),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #4 clk = ~clk;

	// applies one request to the shadow histograms and returns the answer it should get
	function automatic thq_result_t histogram_step(thq_op_e op, logic signed [ETA_W-1:0] eta,
			logic [DEPTH_W-1:0] depth, logic [TDC_W-1:0] tdc, logic [ADC_W-1:0] adc);
		thq_result_t     r;
		int              eta_int;
		int unsigned     mag;
		int unsigned     base;
		bit              in_table;
		longint unsigned total;
		longint unsigned running;
		longint unsigned bound;

		r = '0;
		r.kind = op;
		eta_int = eta;
		mag = (eta_int < 0) ? -eta_int : eta_int;
		in_table = (mag < ETA_ROWS) && (depth < DEPTH_ROWS);
		base = (mag * DEPTH_ROWS + depth) * TDC_BINS;
		if (op == OP_HIT) begin
			hits_seen++;
			if (in_table && adc > thr_shadow) begin
				if (tdc >= TDC_BINS) begin
					r.hit_dropped_code = 1'b1;
					hits_dropped++;
				end else begin
					if (bin_tally[base + tdc] != '1)
						bin_tally[base + tdc]++;
					r.hit_counted = 1'b1;
					hits_counted++;
				end
			end
		end else begin
			queries_seen++;
			if (in_table) begin
				total = 0;
				for (int b = 0; b < TDC_BINS; b++)
					total += bin_tally[base + b];
				r.cell_total = (total > 64'hFFFF_FFFF) ? '1 : total[COUNT_W-1:0];
				if (total != 0) begin
					bound = longint'(permille_shadow) * total;
					running = 0;
					for (int b = 0; b < TDC_BINS; b++) begin
						running += bin_tally[base + b];
						// bin zero feeds the sum but is never the answer
						if (b >= 1 && running * PERMILLE_SCALE > bound) begin
							r.quantile_bin = BIN_OUT_W'(b);
							break;
						end
					end
				end
				if (r.quantile_bin != 0)
					nonzero_answers++;
			end
		end
		return r;
	endfunction

	function automatic hist_req_t random_req();
		hist_req_t   r;
		int unsigned h;
		int unsigned sel;

		h = $urandom_range(HOT_CELLS - 1);
		r.op = ($urandom_range(99) < 15) ? OP_QUERY : OP_HIT;
		r.depth = DEPTH_W'(hot_depth[h]);
		r.eta = ($urandom_range(1) == 1) ? ETA_W'(-int'(hot_mag[h])) : ETA_W'(hot_mag[h]);
		// a share of requests go anywhere, including cells outside the table
		if ($urandom_range(99) < 20) begin
			r.eta = ETA_W'($urandom_range(63));
			r.depth = DEPTH_W'($urandom_range(7));
		end
		sel = $urandom_range(99);
		if (sel < 10)
			r.tdc = TDC_W'($urandom_range(63, TDC_BINS));
		else if (sel < 40)
			r.tdc = TDC_W'($urandom_range(5));
		else
			r.tdc = TDC_W'($urandom_range(TDC_BINS - 1));
		r.adc = ADC_W'($urandom_range(255));
		return r;
	endfunction

	task automatic add_req(thq_op_e op, int eta, int depth, int tdc, int adc);
		hist_req_t r;

		r.op = op;
		r.eta = ETA_W'(eta);
		r.depth = DEPTH_W'(depth);
		r.tdc = TDC_W'(tdc);
		r.adc = ADC_W'(adc);
		pending_reqs.push_back(r);
	endtask

	task automatic write_reg(thq_reg_e idx, int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_ADC_THRESHOLD)
			thr_shadow = value[ADC_W-1:0];
		else
			permille_shadow = value[PERMILLE_W-1:0];
	endtask

	// sampled at the falling edge so the driver's pops and raises have settled
	task automatic wait_idle();
		@(negedge clk);
		while (pending_reqs.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tdc_histogram_quantile_tb: done, errors");
			$finish;
		end
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				expected_results.push_back(histogram_step(thq_op_e'(operation), eta_index,
					depth_index, tdc_code, adc_code));
			if (!item_valid || !item_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_req = pending_reqs.pop_front();
					operation <= next_req.op;
					eta_index <= next_req.eta;
					depth_index <= next_req.depth;
					tdc_code <= next_req.tdc;
					adc_code <= next_req.adc;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		thq_result_t want;

		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("hit_counted", want.hit_counted, hit_counted);
					check_field("hit_dropped_code", want.hit_dropped_code, hit_dropped_code);
					check_field("quantile_bin", want.quantile_bin, quantile_bin);
					check_field("cell_total", want.cell_total, cell_total);
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		foreach (bin_tally[i])
			bin_tally[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_ADC_THRESHOLD, ADC_THRESHOLD_RST);
		write_reg(REG_QUANTILE, PERMILLE_RST);
		settings_used++;

		// directed: empty cell, bin zero, threshold edge, bad codes, table edges
		add_req(OP_QUERY, 0, 0, 0, 0);
		add_req(OP_HIT, 0, 0, 0, 255);
		add_req(OP_QUERY, 0, 0, 63, 255);
		add_req(OP_HIT, 5, 2, 62, 33);
		add_req(OP_HIT, 5, 2, 62, 34);
		add_req(OP_HIT, -5, 2, TDC_BINS, 34);
		add_req(OP_HIT, 5, 2, 63, 200);
		add_req(OP_HIT, -29, 7, TDC_BINS - 1, 34);
		add_req(OP_HIT, 29, 7, 20, 255);
		add_req(OP_HIT, 30, 0, 10, 255);
		add_req(OP_HIT, -30, 1, 10, 255);
		add_req(OP_HIT, 31, 4, 10, 255);
		add_req(OP_HIT, -31, 5, 10, 255);
		add_req(OP_HIT, -32, 6, 10, 255);
		add_req(OP_HIT, -1, 3, 10, 0);
		add_req(OP_QUERY, 29, 7, 0, 0);
		add_req(OP_QUERY, -32, 6, 0, 0);
		add_req(OP_QUERY, 31, 4, 0, 0);
		add_req(OP_QUERY, -30, 1, 0, 0);
		add_req(OP_QUERY, 5, 2, 0, 0);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			send_gap_pct = 0;
			recv_stall_pct = 0;
			wait_idle();
			repeat (4) @(posedge clk);
			// upper data bits are unused by the threshold register
			write_reg(REG_ADC_THRESHOLD, ($urandom_range(3) << ADC_W) | phase_thr[p]);
			write_reg(REG_QUANTILE, phase_perm[p]);
			settings_used++;
			for (int h = 0; h < HOT_CELLS; h++) begin
				hot_mag[h] = $urandom_range(ETA_ROWS - 1);
				hot_depth[h] = $urandom_range(DEPTH_ROWS - 1);
			end
			@(negedge clk);
			send_gap_pct = phase_send[p];
			recv_stall_pct = phase_recv[p];
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_reqs.push_back(random_req());
			wait_idle();
		end

		recv_stall_pct = 0;
		repeat (16) @(posedge clk);
		if (expected_results.size() != 0)
			$error("%0d results never arrived", expected_results.size());
		$display("covered %0d hits (%0d counted, %0d dropped on tdc code) and %0d queries",
			hits_seen, hits_counted, hits_dropped, queries_seen);
		$display("%0d queries gave a nonzero bin across %0d register settings",
			nonzero_answers, settings_used);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("tdc_histogram_quantile_tb: done, clean");
		else
			$display("tdc_histogram_quantile_tb: done, errors");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/thq_pkg.sv
hw/rtl/thq_fifo.sv
hw/rtl/thq_front.sv
hw/rtl/thq_back.sv
hw/rtl/tdc_histogram_quantile.sv
bench/tdc_histogram_quantile_tb.sv
